// ===== rtl/lsra_pkg.sv =====
`timescale 1ns / 1ps
package lsra_pkg;
    localparam int MaxRegs = 16;
    localparam int SlotW = $clog2(MaxRegs);
    localparam int CntW = $clog2(MaxRegs + 1);

    localparam logic [0:0] REG_NUM_REGS = 1'b0;

    typedef struct packed {
        logic        first_of_run;
        logic [15:0] interval_id;
        logic [15:0] start_line;
        logic [15:0] end_line;
    } t_in;

    typedef struct packed {
        logic [3:0]  assigned_reg;
        logic        self_spilled;
        logic        victim_valid;
        logic [15:0] victim_id;
    } t_out;

    typedef struct packed {
        logic clear;   // first-of-run clear, issued instead of expiry
        logic expire;
        logic search;  // victim search / alloc
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_sts;
endpackage

// ===== rtl/lsra_datapath.sv =====
`timescale 1ns / 1ps
module lsra_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  lsra_pkg::t_in     i_item,
    input  logic [4:0]        i_num_regs,
    input  lsra_pkg::t_cmd    i_cmd,
    output lsra_pkg::t_out    o_result
);
    localparam int N = lsra_pkg::MaxRegs;
    localparam int SW = lsra_pkg::SlotW;
    localparam int CW = lsra_pkg::CntW;

    lsra_pkg::t_in r_item;
    logic [N-1:0]  r_valid, n_valid;
    logic [15:0]   r_id [N];
    logic [15:0]   r_start [N];
    logic [15:0]   r_end [N];
    logic [3:0]    r_reg [N];
    logic [15:0]   r_age [N];
    logic [N-1:0]  r_free, n_free;
    logic [15:0]   r_cnt;
    logic [CW-1:0] r_k;
    // search results
    logic          r_tgt_ok;
    logic [SW-1:0] r_tgt;
    logic [3:0]    r_reg_sel;
    logic          r_self, r_vict;
    logic [15:0]   r_vid;
    lsra_pkg::t_out r_out;

    // expiry (combinational over independent slots)
    logic [N-1:0]  exp_mask;
    logic [N-1:0]  free_add;
    always_comb begin
        free_add = '0;
        for (int i = 0; i < N; i++) begin
            exp_mask[i] = r_valid[i] && (r_end[i] <= r_item.start_line);
            if (exp_mask[i]) free_add[r_reg[i][SW-1:0]] = 1'b1;
        end
    end

    // active count
    logic [CW-1:0] active;
    always_comb begin
        active = '0;
        for (int i = 0; i < N; i++) active = active + CW'(r_valid[i]);
    end

    // lowest free register below k, lowest empty slot
    logic          fr_found, em_found;
    logic [SW-1:0] fr_idx, em_idx;
    always_comb begin
        fr_found = 1'b0; fr_idx = '0; em_found = 1'b0; em_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_free[i] && (CW'(i) < r_k)) begin
                fr_found = 1'b1; fr_idx = SW'(i);
            end
            if (!r_valid[i]) begin
                em_found = 1'b1; em_idx = SW'(i);
            end
        end
    end

    // victim search: balanced tournament over the slots. On a full tie the
    // higher slot wins; the best active then has to beat the new interval
    // on end or lifetime, since the new interval is the most recent.
    logic [15:0]        t_end  [2*N];
    logic signed [16:0] t_life [2*N];
    logic [16:0]        t_rec  [2*N];
    logic               t_ok   [2*N];
    logic [SW-1:0]      t_idx  [2*N];
    logic signed [16:0] new_life;
    logic               bany;
    logic [SW-1:0]      bidx;
    always_comb begin
        logic hi_wins;
        t_ok[0] = 1'b0; t_end[0] = '0; t_life[0] = '0; t_rec[0] = '0; t_idx[0] = '0;
        for (int i = 0; i < N; i++) begin
            t_ok[N+i] = r_valid[i];
            t_end[N+i] = r_end[i];
            t_life[N+i] = $signed({1'b0, r_end[i]}) - $signed({1'b0, r_start[i]});
            t_rec[N+i] = {1'b0, r_cnt - r_age[i]} + 17'd1;
            t_idx[N+i] = SW'(i);
        end
        for (int j = N - 1; j >= 1; j--) begin
            hi_wins = t_ok[2*j+1] && (!t_ok[2*j] ||
                      (t_end[2*j+1] > t_end[2*j]) ||
                      (t_end[2*j+1] == t_end[2*j] && t_life[2*j+1] < t_life[2*j]) ||
                      (t_end[2*j+1] == t_end[2*j] && t_life[2*j+1] == t_life[2*j] &&
                       t_rec[2*j+1] <= t_rec[2*j]));
            t_ok[j] = t_ok[2*j] || t_ok[2*j+1];
            t_end[j] = hi_wins ? t_end[2*j+1] : t_end[2*j];
            t_life[j] = hi_wins ? t_life[2*j+1] : t_life[2*j];
            t_rec[j] = hi_wins ? t_rec[2*j+1] : t_rec[2*j];
            t_idx[j] = hi_wins ? t_idx[2*j+1] : t_idx[2*j];
        end
        new_life = $signed({1'b0, r_item.end_line}) - $signed({1'b0, r_item.start_line});
        bany = t_ok[1] && ((t_end[1] > r_item.end_line) ||
               (t_end[1] == r_item.end_line && t_life[1] < new_life));
        bidx = t_idx[1];
    end

    always_comb begin
        n_valid = r_valid;
        n_free = r_free;
        if (i_cmd.clear) begin
            n_valid = '0; n_free = '1;
        end else if (i_cmd.expire) begin
            n_valid = r_valid & ~exp_mask;
            n_free = r_free | free_add;
        end else if (i_cmd.commit && r_tgt_ok) begin
            n_valid[r_tgt] = 1'b1;
            if (!r_vict) n_free[r_reg_sel[SW-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_free <= '1;
            r_cnt <= '0;
            r_tgt_ok <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_free <= n_free;
            if (i_cmd.clear) r_cnt <= '0;
            else if (i_cmd.commit && r_tgt_ok) r_cnt <= r_cnt + 16'd1;
            if (i_cmd.search) begin
                r_tgt_ok <= 1'b0;
                if (active < r_k) begin
                    r_tgt_ok <= fr_found && em_found;
                end else begin
                    r_tgt_ok <= bany;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
            if (i_num_regs == 5'd0) r_k <= CW'(1);
            else if (32'(i_num_regs) > N) r_k <= CW'(N);
            else r_k <= CW'(i_num_regs);
        end
        if (i_cmd.search) begin
            if (active < r_k) begin
                r_tgt <= em_idx;
                r_reg_sel <= 4'(fr_idx);
                r_self <= !(fr_found && em_found);
                r_vict <= 1'b0;
                r_vid <= '0;
            end else begin
                r_tgt <= bidx;
                r_reg_sel <= r_reg[bidx];
                r_self <= !bany;
                r_vict <= bany;
                r_vid <= bany ? r_id[bidx] : 16'd0;
            end
        end
        if (i_cmd.commit) begin
            if (r_tgt_ok) begin
                r_id[r_tgt] <= r_item.interval_id;
                r_start[r_tgt] <= r_item.start_line;
                r_end[r_tgt] <= r_item.end_line;
                r_reg[r_tgt] <= r_reg_sel;
                r_age[r_tgt] <= r_cnt;
            end
            r_out.assigned_reg <= r_self ? 4'd0 : r_reg_sel;
            r_out.self_spilled <= r_self;
            r_out.victim_valid <= r_vict;
            r_out.victim_id <= r_vid;
        end
    end

    assign o_result = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_tgt_ok && !r_vict |-> !r_valid[r_tgt])
        else $error("commit into occupied slot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_valid == '0) && (r_cnt == '0))
        else $error("clear did not empty state");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_self |-> !r_vict)
        else $error("self spill with victim");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(i_cmd) <= 1)
        else $error("multiple commands");
endmodule

// ===== rtl/lsra_ctrl.sv =====
`timescale 1ns / 1ps
module lsra_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_first,
    output logic           o_stall,
    output logic           o_load,
    output lsra_pkg::t_cmd o_cmd,
    output logic           o_valid,
    input  logic           i_stall
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXP  = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_COMM = 3'd3;

    logic [2:0] r_state, n_state;
    logic       r_first;
    logic       r_ovalid, n_ovalid;

    // hold off new work until the current transaction has committed
    assign o_stall = (r_state != S_IDLE);
    assign o_load = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        n_ovalid = r_ovalid && i_stall;
        unique case (r_state)
            S_IDLE: if (o_load) n_state = S_EXP;
            S_EXP: begin
                if (r_first) o_cmd.clear = 1'b1;
                else o_cmd.expire = 1'b1;
                // after clear nothing can expire, so go straight on
                n_state = S_SRCH;
            end
            S_SRCH: begin
                o_cmd.search = 1'b1;
                n_state = S_COMM;
            end
            S_COMM: begin
                if (!n_ovalid) begin
                    o_cmd.commit = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            if (o_load) r_first <= i_first;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_ovalid)
        else $error("commit without result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_load |=> r_state == S_EXP)
        else $error("load did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.search |=> r_state == S_COMM)
        else $error("search sequence broken");
endmodule

// ===== rtl/linear_scan_register_allocator.sv =====
`timescale 1ns / 1ps
// Linear-scan register allocator.
// Each accepted interval passes through expire, search and commit; commit waits while the output stalls.
// A new interval is accepted only after the current one has committed.
// Reset: synchronous active low; empties active set, marks all registers free, clears counter, num_regs to 16.
module linear_scan_register_allocator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lsra_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output lsra_pkg::t_out o_data,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    logic [4:0]     r_num_regs;
    logic           load;
    lsra_pkg::t_cmd cmd;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_num_regs <= 5'd16;
        else if (psel && penable && pwrite && paddr[2] == lsra_pkg::REG_NUM_REGS
                 && paddr[1:0] == 2'b00)
            r_num_regs <= pwdata[4:0];
    end
    assign prdata = (paddr[2] == lsra_pkg::REG_NUM_REGS) ? {27'd0, r_num_regs} : 32'd0;

    lsra_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .i_first(i_data.first_of_run), .o_stall,
        .o_load(load), .o_cmd(cmd), .o_valid, .i_stall
    );

    lsra_datapath u_dp (
        .i_clk, .i_rst_n, .i_load(load), .i_item(i_data), .i_num_regs(r_num_regs),
        .i_cmd(cmd), .o_result(o_data)
    );
endmodule
